>>> rtl/esqp_pkg.sv
// Shared constants for the elasticity flux block.
package esqp_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_DIM_DEF = 3;

  localparam logic [2:0] OP_GRAD = 3'd0;
  localparam logic [2:0] OP_JAC = 3'd1;
  localparam logic [2:0] OP_LAMBDA = 3'd2;
  localparam logic [2:0] OP_MU = 3'd3;
  localparam logic [2:0] OP_WEIGHT = 3'd4;
  localparam logic [2:0] OP_COMPUTE = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
endpackage

>>> rtl/elastic_stress_quadrature_point.sv
// Top level of the elasticity flux block: operand stores, sequencer, shared multiplier.
//  channel | handshake        | payload
//  in      | start / busy     | op, row, col, value
//  cfg     | cfg_valid/ready  | cfg_data (dimension)
//  out     | strobe           | out_row, out_col, out_value, status, last
// A compute runs a microcode sequence on one shared 32x32 multiplier, one
// product per cycle, plus one divide per P entry that holds the sequencer
// until the divider is done. Busy stays high from cofactor and determinant
// work through the last result, mostly waiting on the divider when det is nonzero.
// Results leave one per cycle, the last one in the cycle busy falls.
// Reset is synchronous; the receiver cannot stall.
module elastic_stress_quadrature_point #(
  parameter int FRAC_BITS = esqp_pkg::FRAC_BITS_DEF,
  parameter int MAX_DIM = esqp_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  output logic               strobe,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last
);
  import esqp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_COF  = 10'b0000000010, S_DET = 10'b0000000100,
    S_H    = 10'b0000001000, S_DIV  = 10'b0000010000, S_TR  = 10'b0000100000,
    S_SIG  = 10'b0001000000, S_OUT  = 10'b0010000000, S_W   = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  state_t state;
  logic signed [31:0] g [3][3];
  logic signed [31:0] jm [3][3];
  logic signed [31:0] cm [3][3];
  logic signed [31:0] pm [3][3];
  logic signed [31:0] res [3][3];
  logic signed [31:0] lam, mu, wt, det, lt;
  logic [1:0] dim;
  logic [1:0] i, j, k;
  logic [1:0] n;
  logic sub;
  logic signed [63:0] acc;
  logic sat_hit, sing;
  logic div_go, div_done;
  logic signed [63:0] div_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v, output logic f);
    f = (v > MAX32) || (v < MIN32);
    return (v > MAX32) ? 32'sh7fffffff : (v < MIN32) ? 32'sh80000000 : v[31:0];
  endfunction

  function automatic logic [1:0] m3(input logic [1:0] a, input logic [1:0] d);
    logic [2:0] s;
    s = 3'(a) + 3'(d);
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  assign n = (dim == 2'd2 || MAX_DIM == 2) ? 2'd2 : 2'd3;
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  esqp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(32'(acc)), .den(det),
    .done(div_done), .quot(div_q)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_COF: begin
        if (n == 2'd2) begin
          ma = '0; mb = '0;
        end else if (!sub) begin
          ma = jm[m3(i,2'd1)][m3(j,2'd1)]; mb = jm[m3(i,2'd2)][m3(j,2'd2)];
        end else begin
          ma = jm[m3(i,2'd1)][m3(j,2'd2)]; mb = jm[m3(i,2'd2)][m3(j,2'd1)];
        end
      end
      S_DET: begin
        if (n == 2'd2) begin
          ma = sub ? jm[0][1] : jm[0][0]; mb = sub ? jm[1][0] : jm[1][1];
        end else begin
          ma = jm[0][k]; mb = cm[0][k];
        end
      end
      S_H:   begin ma = g[i][k]; mb = cm[j][k]; end
      S_TR:  begin ma = lam; mb = 32'(acc); end
      S_SIG: begin
        ma = mu;
        mb = 32'((65'(pm[i][j]) + 65'(pm[j][i]) + 65'sd1) >>> 1);
      end
      S_OUT: begin ma = res[i][k]; mb = cm[k][j]; end
      S_W:   begin ma = 32'(acc); mb = wt; end
      default: ;
    endcase
    prod = (64'(ma) * 64'(mb) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    logic f, f2;
    logic signed [31:0] t;
    div_go <= 1'b0;
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      dim <= 2'd3;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) dim <= cfg_data;
          if (start) begin
            case (op)
              OP_GRAD:   if (row < 2'(MAX_DIM) && col < 2'(MAX_DIM)) g[row][col] <= value;
              OP_JAC:    if (row < 2'(MAX_DIM) && col < 2'(MAX_DIM)) jm[row][col] <= value;
              OP_LAMBDA: lam <= value;
              OP_MU:     mu <= value;
              OP_WEIGHT: wt <= value;
              OP_COMPUTE: begin
                sat_hit <= 1'b0; i <= '0; j <= '0; k <= '0; sub <= 1'b0;
                acc <= '0; state <= S_COF;
              end
              default: ;
            endcase
          end
        end
        S_COF: begin
          if (n == 2'd2) begin
            cm[0][0] <= jm[1][1]; cm[1][1] <= jm[0][0];
            cm[0][1] <= sat32(-64'(jm[1][0]), f);
            cm[1][0] <= sat32(-64'(jm[0][1]), f2);
            sat_hit <= sat_hit | f | f2;
            cm[2] <= '{default: '0}; cm[0][2] <= '0; cm[1][2] <= '0;
            state <= S_DET; acc <= '0; sub <= 1'b0; k <= '0;
          end else if (!sub) begin
            acc <= prod; sub <= 1'b1;
          end else begin
            cm[i][j] <= sat32(acc - prod, f);
            sat_hit <= sat_hit | f;
            sub <= 1'b0;
            if (j == 2'd2) begin
              j <= '0;
              if (i == 2'd2) begin
                i <= '0; acc <= '0; k <= '0; state <= S_DET;
              end else i <= i + 1'b1;
            end else j <= j + 1'b1;
          end
        end
        S_DET: begin
          if (n == 2'd2) begin
            if (!sub) begin
              acc <= prod; sub <= 1'b1;
            end else begin
              t = sat32(acc - prod, f);
              det <= t; sat_hit <= sat_hit | f; sub <= 1'b0;
              sing <= (t == 0); acc <= '0; i <= '0; j <= '0; k <= '0;
              state <= (t == 0) ? S_EMIT : S_H;
            end
          end else if (k == 2'd2) begin
            t = sat32(acc + prod, f);
            det <= t; sat_hit <= sat_hit | f;
            sing <= (t == 0); acc <= '0; i <= '0; j <= '0; k <= '0;
            state <= (t == 0) ? S_EMIT : S_H;
          end else begin
            acc <= acc + prod; k <= k + 1'b1;
          end
        end
        S_H: begin
          if (k == n - 1'b1) begin
            acc <= 64'(sat32(acc + prod, f)); sat_hit <= sat_hit | f;
            k <= '0; div_go <= 1'b1; state <= S_DIV;
          end else begin
            acc <= acc + prod; k <= k + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pm[i][j] <= sat32(div_q, f); sat_hit <= sat_hit | f;
            acc <= '0;
            if (j == n - 1'b1) begin
              j <= '0;
              if (i == n - 1'b1) begin
                i <= '0; state <= S_TR;
              end else i <= i + 1'b1;
            end else j <= j + 1'b1;
            if (!(j == n - 1'b1 && i == n - 1'b1)) state <= S_H;
          end
        end
        S_TR: begin
          // First pass sums the trace into acc, then one multiply by lambda.
          if (!sub) begin
            if (k == n) begin
              acc <= 64'(sat32(acc, f)); sat_hit <= sat_hit | f; sub <= 1'b1;
            end else begin
              acc <= acc + 64'(pm[k][k]); k <= k + 1'b1;
            end
          end else begin
            lt <= sat32(prod, f); sat_hit <= sat_hit | f;
            sub <= 1'b0; k <= '0; i <= '0; j <= '0; state <= S_SIG;
          end
        end
        S_SIG: begin
          res[i][j] <= sat32((prod <<< 1) + ((i == j) ? 64'(lt) : 64'sd0), f);
          sat_hit <= sat_hit | f;
          if (j == n - 1'b1) begin
            j <= '0;
            if (i == n - 1'b1) begin
              i <= '0; acc <= '0; k <= '0; state <= S_OUT;
            end else i <= i + 1'b1;
          end else j <= j + 1'b1;
        end
        S_OUT: begin
          if (k == n - 1'b1) begin
            acc <= 64'(sat32(acc + prod, f)); sat_hit <= sat_hit | f;
            k <= '0; state <= S_W;
          end else begin
            acc <= acc + prod; k <= k + 1'b1;
          end
        end
        S_W: begin
          // Results go to pm so that res stays intact for the later entries of each row.
          pm[i][j] <= sat32(prod, f); sat_hit <= sat_hit | f;
          acc <= '0;
          if (j == n - 1'b1) begin
            j <= '0;
            if (i == n - 1'b1) begin
              i <= '0; state <= S_EMIT;
            end else i <= i + 1'b1;
          end else j <= j + 1'b1;
          if (!(j == n - 1'b1 && i == n - 1'b1)) state <= S_OUT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          out_row <= i; out_col <= j;
          out_value <= sing ? 32'sd0 : pm[i][j];
          status <= sing ? ST_SINGULAR : (sat_hit ? ST_SAT : ST_OK);
          last <= (i == n - 1'b1) && (j == n - 1'b1);
          if (j == n - 1'b1) begin
            j <= '0;
            if (i == n - 1'b1) begin
              i <= '0; state <= S_IDLE;
            end else i <= i + 1'b1;
          end else j <= j + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/esqp_div.sv
// Restoring divider, one quotient bit per cycle, rounding to nearest, ties away.
module esqp_div #(
  parameter int FRAC_BITS = esqp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [63:0] quot
);
  import esqp_pkg::*;
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] un, q;
  logic [32:0] rem;
  logic [31:0] ud;
  logic neg, run;
  logic [CW-1:0] cnt;
  logic [32:0] trial;
  logic [63:0] qr;

  always_comb begin
    trial = {rem[31:0], un[NW-1]} - {1'b0, ud};
    // Round: add half the divisor, equivalent to comparing 2*rem with ud.
    qr = 64'(q) + (({rem, 1'b0} >= {1'b0, ud, 1'b0} - 34'(ud)) ? 64'd1 : 64'd0);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= CW'(NW);
      un <= NW'(num[31] ? -(33'(num)) : 33'(num)) << FRAC_BITS;
      ud <= den[31] ? 32'(-(33'(den))) : den;
      neg <= num[31] ^ den[31];
      rem <= '0;
      q <= '0;
    end else if (run) begin
      if (cnt != '0) begin
        un <= un << 1;
        if (!trial[32]) begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[31:0], un[NW-1]};
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end else begin
        run <= 1'b0;
        done <= 1'b1;
        quot <= neg ? -$signed(qr) : $signed(qr);
      end
    end
  end
endmodule

>>> rtl/esqp_checker.sv
// Port-level checks for the elasticity flux block, bound to the top level.
module esqp_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       cfg_ready,
  input logic       strobe,
  input logic       last,
  input logic [1:0] status
);
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready == !busy)
    else $error("cfg_ready disagrees with busy");
  a_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy || last)
    else $error("result outside a transaction");
  a_end: assert property (@(posedge clk) disable iff (rst) strobe && last |=> !strobe)
    else $error("result after last");
  a_stat: assert property (@(posedge clk) disable iff (rst) strobe |-> status != 2'd3)
    else $error("bad status");
endmodule

bind elastic_stress_quadrature_point esqp_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .cfg_ready(cfg_ready),
  .strobe(strobe), .last(last), .status(status)
);
